@@ rtl/wpb_pkg.sv @@
// shared types and constants for the weighted pixel blend
package wpb_pkg;

  localparam int CH_W      = 16;
  localparam int WGT_W     = 17;
  localparam int BYTE_W    = 8;
  localparam int BG_W      = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROJECTION_ONLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_RGB  = 2'd1;

  // classified item queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // restoring divider: one quotient bit per cycle, top bit flags overflow
  localparam int               Q_BITS    = 9;
  localparam int               STEP_W    = 4;
  localparam logic [STEP_W-1:0] DIV_LAST = 4'd8;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic                take;      // contribution goes into the sums
    logic                first;     // first contribution of the run
    logic                interior;
    logic                resolve;   // run ends with this item
    logic                covered;   // run had at least one contribution
    chan_t [2:0]         ch;
    logic [WGT_W-1:0]    wgt;       // already saturated to one
  } item_t;

endpackage

@@ rtl/wpb_front.sv @@
// front end: classifies incoming contributions and tracks the run length
module wpb_front import wpb_pkg::*; #(
  parameter int MAX_CONTRIBUTIONS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             present,
  input  chan_t            chan0,
  input  chan_t            chan1,
  input  chan_t            chan2,
  input  logic [WGT_W-1:0] weight,
  input  logic             interior,
  input  logic             last,
  output item_t            item
);

  localparam int CNT_W = $clog2(MAX_CONTRIBUTIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTRIBUTIONS);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             under_lim;

  assign under_lim = (cnt_r < CNT_MAX);

  always_comb begin
    item.take     = present & under_lim;
    item.first    = (cnt_r == '0);
    item.interior = interior;
    item.resolve  = ~present | last;
    item.covered  = present | (cnt_r != '0);
    item.ch[0]    = chan0;
    item.ch[1]    = chan1;
    item.ch[2]    = chan2;
    item.wgt      = (weight > WGT_ONE) ? WGT_ONE : weight;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (item.resolve) begin
        cnt_nxt = '0;
      end else if (item.take) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/wpb_queue.sv @@
// short queue of classified items between front and back
module wpb_queue import wpb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  item_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + (Q_AW+1)'(1);
        2'b01:   count_r <= count_r - (Q_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/wpb_back.sv @@
// back end: accumulates contributions, divides at run end, holds the result
module wpb_back import wpb_pkg::*; #(
  parameter int MAX_CONTRIBUTIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  item_t             q_data,
  output logic              q_pop,
  input  logic              projection_only,
  input  logic [BG_W-1:0]   background_rgb,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [BYTE_W-1:0] out0,
  output logic [BYTE_W-1:0] out1,
  output logic [BYTE_W-1:0] out2,
  output logic              out_covered
);

  localparam int LG    = $clog2(MAX_CONTRIBUTIONS);
  localparam int SUM_W = 32 + LG;
  localparam int WT_W  = WGT_W + LG;
  localparam int DW    = WT_W + 8;

  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t state_r;

  logic [SUM_W-1:0] isum_r [3];
  logic [SUM_W-1:0] osum_r [3];
  logic [SUM_W-1:0] isum_nxt [3];
  logic [SUM_W-1:0] osum_nxt [3];
  logic [SUM_W-1:0] sel_sum [3];
  logic [WT_W-1:0]  iwt_r, owt_r, iwt_nxt, owt_nxt, sel_wt;
  logic             saw_int_r, saw_int_nxt;
  chan_t            first_r [3];
  chan_t            first_nxt [3];
  logic [32:0]      prod [3];

  logic [DW-1:0]     rem_r [3];
  logic [DW-1:0]     dvs_r;
  logic [Q_BITS-1:0] quo_r [3];
  logic [STEP_W-1:0] step_r;
  logic              cov_r, proj_r, wzero_r;
  logic [BYTE_W-1:0] res_first_r [3];

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r [3];
  logic              out_cov_r;
  logic              slot_free;
  logic [BYTE_W-1:0] res_byte [3];

  assign q_pop       = (state_r == ST_ACC) & ~q_empty;
  assign slot_free   = ~out_valid_r | out_pop;
  assign out_empty   = ~out_valid_r;
  assign out0        = out_byte_r[0];
  assign out1        = out_byte_r[1];
  assign out2        = out_byte_r[2];
  assign out_covered = out_cov_r;

  // accumulator update for the request at the queue head
  always_comb begin
    saw_int_nxt = saw_int_r;
    iwt_nxt     = iwt_r;
    owt_nxt     = owt_r;
    for (int c = 0; c < 3; c++) begin
      prod[c]      = {17'b0, q_data.ch[c]} * {16'b0, q_data.wgt};
      isum_nxt[c]  = isum_r[c];
      osum_nxt[c]  = osum_r[c];
      first_nxt[c] = first_r[c];
      if (q_data.take) begin
        if (q_data.interior) begin
          isum_nxt[c] = isum_r[c] + SUM_W'(prod[c]);
        end else begin
          osum_nxt[c] = osum_r[c] + SUM_W'(prod[c]);
        end
        if (q_data.first) begin
          first_nxt[c] = q_data.ch[c];
        end
      end
    end
    if (q_data.take) begin
      if (q_data.interior) begin
        iwt_nxt     = iwt_r + WT_W'(q_data.wgt);
        saw_int_nxt = 1'b1;
      end else begin
        owt_nxt = owt_r + WT_W'(q_data.wgt);
      end
    end
    // interior contributions win over overlap ones when any exist
    sel_wt = saw_int_nxt ? iwt_nxt : owt_nxt;
    for (int c = 0; c < 3; c++) begin
      sel_sum[c] = saw_int_nxt ? isum_nxt[c] : osum_nxt[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!cov_r) begin
        res_byte[c] = background_rgb[c*BYTE_W +: BYTE_W];
      end else if (proj_r) begin
        res_byte[c] = res_first_r[c];
      end else if (wzero_r) begin
        res_byte[c] = background_rgb[c*BYTE_W +: BYTE_W];
      end else if (quo_r[c][Q_BITS-1]) begin
        res_byte[c] = {BYTE_W{1'b1}};
      end else begin
        res_byte[c] = quo_r[c][BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      saw_int_r   <= 1'b0;
      iwt_r       <= '0;
      owt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      for (int c = 0; c < 3; c++) begin
        isum_r[c]  <= '0;
        osum_r[c]  <= '0;
        first_r[c] <= '0;
      end
    end else begin
      if ((state_r == ST_DONE) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_ACC: begin
          if (q_pop) begin
            if (q_data.resolve) begin
              // snapshot the run and clear for the next pixel
              cov_r   <= q_data.covered;
              proj_r  <= projection_only;
              wzero_r <= (sel_wt == '0);
              dvs_r   <= DW'(sel_wt) << 8;
              step_r  <= '0;
              for (int c = 0; c < 3; c++) begin
                rem_r[c]       <= DW'(sel_sum[c] >> 8);
                quo_r[c]       <= '0;
                res_first_r[c] <= first_nxt[c][CH_W-1 -: BYTE_W];
                isum_r[c]      <= '0;
                osum_r[c]      <= '0;
                first_r[c]     <= '0;
              end
              iwt_r     <= '0;
              owt_r     <= '0;
              saw_int_r <= 1'b0;
              state_r   <= ST_DIV;
            end else begin
              for (int c = 0; c < 3; c++) begin
                isum_r[c]  <= isum_nxt[c];
                osum_r[c]  <= osum_nxt[c];
                first_r[c] <= first_nxt[c];
              end
              iwt_r     <= iwt_nxt;
              owt_r     <= owt_nxt;
              saw_int_r <= saw_int_nxt;
            end
          end
        end
        ST_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (rem_r[c] >= dvs_r) begin
              rem_r[c] <= rem_r[c] - dvs_r;
              quo_r[c] <= {quo_r[c][Q_BITS-2:0], 1'b1};
            end else begin
              quo_r[c] <= {quo_r[c][Q_BITS-2:0], 1'b0};
            end
          end
          dvs_r  <= dvs_r >> 1;
          step_r <= step_r + STEP_W'(1);
          if (step_r == DIV_LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_r <= ST_ACC;
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && slot_free) begin
      out_cov_r <= cov_r;
      for (int c = 0; c < 3; c++) begin
        out_byte_r[c] <= res_byte[c];
      end
    end
  end

endmodule

@@ rtl/weighted_pixel_blend.sv @@
// weighted pixel blend: resolves one output pixel from a run of camera contributions
//
// input channel: push a request while full is low; one request per contribution,
// the run ends with last set or with a request whose present bit is low.
// result channel: one result per run, shown while empty is low, taken with pop.
// config channel: cfg_ready is always high; the user must make writes only while the
// block is idle, which the block does not enforce; register 0 is projection_only
// and register 1 is background_rgb. throughput: one contribution per cycle through a
// 4-entry queue into the accumulators (one 16x17 multiply-add per channel) while the
// back end is accumulating; at the end of a run it stops taking contributions while
// it runs the three 9-step restoring divisions and writes the result once the output
// register is free. when the receiver stalls, the finished result waits in the output
// register while the next run is accumulated and divided; that result then waits in
// the back end, the queue fills and full rises. reset clears the queue, the
// accumulators, the valid flag of the result register and both configuration
// registers.
module weighted_pixel_blend import wpb_pkg::*; #(
  parameter int MAX_CONTRIBUTIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_present,
  input  logic [CH_W-1:0]      in_chan0,
  input  logic [CH_W-1:0]      in_chan1,
  input  logic [CH_W-1:0]      in_chan2,
  input  logic [WGT_W-1:0]     in_weight,
  input  logic                 in_interior,
  input  logic                 in_last,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [BYTE_W-1:0]    out_out0,
  output logic [BYTE_W-1:0]    out_out1,
  output logic [BYTE_W-1:0]    out_out2,
  output logic                 out_covered,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BG_W-1:0]      cfg_wdata
);

  logic            proj_r;
  logic [BG_W-1:0] bg_r;
  logic            q_full, q_empty, q_pop, accept;
  item_t           front_item, q_item;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proj_r <= 1'b0;
      bg_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PROJECTION_ONLY) begin
        proj_r <= cfg_wdata[0];
      end else if (cfg_index == REG_BACKGROUND_RGB) begin
        bg_r <= cfg_wdata;
      end
    end
  end

  wpb_front #(
    .MAX_CONTRIBUTIONS(MAX_CONTRIBUTIONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .present  (in_present),
    .chan0    (in_chan0),
    .chan1    (in_chan1),
    .chan2    (in_chan2),
    .weight   (in_weight),
    .interior (in_interior),
    .last     (in_last),
    .item     (front_item)
  );

  wpb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (front_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  wpb_back #(
    .MAX_CONTRIBUTIONS(MAX_CONTRIBUTIONS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_item),
    .q_pop           (q_pop),
    .projection_only (proj_r),
    .background_rgb  (bg_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out0            (out_out0),
    .out1            (out_out1),
    .out2            (out_out2),
    .out_covered     (out_covered)
  );

endmodule

@@ tb/weighted_pixel_blend_tb.sv @@
// self-checking testbench for the weighted pixel blend: directed table, then random pixel runs
module weighted_pixel_blend_tb;
  import wpb_pkg::*;

  localparam int MAX_CONTRIB  = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 5;
  localparam int SETTLE_CYC   = 20;
  localparam int LONG_STALL   = 400;
  localparam logic [BG_W-1:0] BG_TEAL  = 24'hA55AC3;
  localparam logic [BG_W-1:0] BG_WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic             present;
    chan_t            c0;
    chan_t            c1;
    chan_t            c2;
    logic [WGT_W-1:0] wgt;
    logic             interior;
    logic             last;
  } contrib_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              covered;
  } pixel_t;

  typedef struct packed {
    logic            proj;
    logic [BG_W-1:0] bg;
    contrib_t        it;
    logic            known;
    pixel_t          px;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_present = 1'b0;
  logic [CH_W-1:0]      in_chan0 = '0;
  logic [CH_W-1:0]      in_chan1 = '0;
  logic [CH_W-1:0]      in_chan2 = '0;
  logic [WGT_W-1:0]     in_weight = '0;
  logic                 in_interior = 1'b0;
  logic                 in_last = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [BYTE_W-1:0]    out_out0;
  logic [BYTE_W-1:0]    out_out1;
  logic [BYTE_W-1:0]    out_out2;
  logic                 out_covered;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BG_W-1:0]      cfg_wdata = '0;

  weighted_pixel_blend uut (.*);

  always #6 clk = ~clk;

  // predicted blend state
  logic [63:0]     int_sum [3];
  logic [63:0]     ovl_sum [3];
  logic [20:0]     int_wt;
  logic [20:0]     ovl_wt;
  logic            saw_int;
  chan_t           first_ch [3];
  logic            have_first;
  int unsigned     run_n;
  logic            cur_proj = 1'b0;
  logic [BG_W-1:0] cur_bg = '0;

  pixel_t pending_px [$];
  row_t   dir_rows [$];
  int     n_items = 0;
  int     n_pixels = 0;
  int     n_errors = 0;
  int     n_settings = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  bit     long_done = 1'b0;

  function void clear_run();
    for (int c = 0; c < 3; c++) begin
      int_sum[c] = '0;
      ovl_sum[c] = '0;
      first_ch[c] = '0;
    end
    int_wt = '0;
    ovl_wt = '0;
    saw_int = 1'b0;
    have_first = 1'b0;
    run_n = 0;
  endfunction

  function pixel_t background_px(input logic cov);
    pixel_t px;
    px.b0 = cur_bg[7:0];
    px.b1 = cur_bg[15:8];
    px.b2 = cur_bg[23:16];
    px.covered = cov;
    return px;
  endfunction

  function pixel_t resolve_px();
    pixel_t      px;
    logic [63:0] q [3];
    logic [20:0] wt;
    if (run_n == 0) return background_px(1'b0);
    if (cur_proj) begin
      px.b0 = first_ch[0][15:8];
      px.b1 = first_ch[1][15:8];
      px.b2 = first_ch[2][15:8];
      px.covered = 1'b1;
      return px;
    end
    // interior contributions win over overlap ones when there are any
    wt = saw_int ? int_wt : ovl_wt;
    if (wt == 0) return background_px(1'b1);
    for (int c = 0; c < 3; c++) begin
      q[c] = (saw_int ? int_sum[c] : ovl_sum[c]) / {35'd0, wt, 8'd0};
      if (q[c] > 64'd255) q[c] = 64'd255;
    end
    px.b0 = q[0][7:0];
    px.b1 = q[1][7:0];
    px.b2 = q[2][7:0];
    px.covered = 1'b1;
    return px;
  endfunction

  // returns 1 when the request closes a pixel
  function logic blend_accept(input contrib_t it, output pixel_t px);
    chan_t            ch [3];
    logic [WGT_W-1:0] w;
    ch[0] = it.c0;
    ch[1] = it.c1;
    ch[2] = it.c2;
    w = (it.wgt > WGT_ONE) ? WGT_ONE : it.wgt;
    px = '0;
    if (!it.present) begin
      px = resolve_px();
      clear_run();
      return 1'b1;
    end
    if (run_n < MAX_CONTRIB) begin
      if (!have_first) begin
        first_ch = ch;
        have_first = 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
        if (it.interior) int_sum[c] += 64'(ch[c]) * 64'(w);
        else ovl_sum[c] += 64'(ch[c]) * 64'(w);
      end
      if (it.interior) begin
        int_wt += 21'(w);
        saw_int = 1'b1;
      end else begin
        ovl_wt += 21'(w);
      end
      run_n++;
    end
    if (it.last) begin
      px = resolve_px();
      clear_run();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function row_t make_row(input logic proj, input logic [BG_W-1:0] bg, input logic present,
                          input chan_t c0, input chan_t c1, input chan_t c2,
                          input logic [WGT_W-1:0] w, input logic intr, input logic last,
                          input logic known, input logic [BYTE_W-1:0] b0,
                          input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                          input logic cov);
    row_t r;
    r.proj = proj;
    r.bg = bg;
    r.it = '{present, c0, c1, c2, w, intr, last};
    r.known = known;
    r.px = '{b0, b1, b2, cov};
    return r;
  endfunction

  function void add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFF00;
      2:       return 16'hFFFF;
      default: return chan_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function contrib_t rand_contrib(input logic intr);
    contrib_t it;
    it.present = 1'b1;
    it.c0 = rand_chan();
    it.c1 = rand_chan();
    it.c2 = rand_chan();
    case ($urandom_range(0, 7))
      0:       it.wgt = '0;
      1:       it.wgt = WGT_ONE;
      2:       it.wgt = WGT_W'($urandom_range(65537, 131071));
      3:       it.wgt = WGT_W'($urandom_range(0, 255));
      default: it.wgt = WGT_W'($urandom_range(0, 65536));
    endcase
    it.interior = intr;
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic push_item(input contrib_t it, input logic known, input pixel_t typed);
    pixel_t px;
    in_push <= 1'b1;
    in_present <= it.present;
    in_chan0 <= it.c0;
    in_chan1 <= it.c1;
    in_chan2 <= it.c2;
    in_weight <= it.wgt;
    in_interior <= it.interior;
    in_last <= it.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (blend_accept(it, px)) pending_px.insert(pending_px.size(), known ? typed : px);
    n_items++;
  endtask

  // wait for every pending pixel, then let the back end go quiet
  task automatic settle();
    in_push <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROJECTION_ONLY: cur_proj = data[0];
      REG_BACKGROUND_RGB:  cur_bg = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic proj, input logic [BG_W-1:0] bg);
    write_reg(REG_PROJECTION_ONLY, {{(BG_W-1){1'b0}}, proj});
    write_reg(REG_BACKGROUND_RGB, bg);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic gen_run();
    contrib_t it;
    pixel_t   none;
    int       len;
    int       mix;
    logic     by_absent;
    none = '0;
    if ($urandom_range(0, 15) == 0) begin
      it = rand_contrib(1'($urandom_range(0, 1)));
      it.present = 1'b0;
      sender_gap();
      push_item(it, 1'b0, none);
      return;
    end
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_CONTRIB - 1, MAX_CONTRIB + 4)
                                       : $urandom_range(1, 6);
    mix = $urandom_range(0, 2);
    by_absent = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < len; k++) begin
      it = rand_contrib(mix == 2 ? logic'($urandom_range(0, 1)) : logic'(mix));
      it.last = (k == len - 1) && !by_absent;
      sender_gap();
      push_item(it, 1'b0, none);
    end
    if (by_absent) begin
      // run closed by a request without a contribution
      it = rand_contrib(1'($urandom_range(0, 1)));
      it.present = 1'b0;
      sender_gap();
      push_item(it, 1'b0, none);
    end
  endtask

  // result side: check, then decide the next pop
  initial begin
    pixel_t px;
    int     stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_px.size() == 0) begin
          flag_error($sformatf("result %h %h %h cov %b with nothing pending",
                               out_out0, out_out1, out_out2, out_covered));
        end else begin
          px = pending_px.pop_front();
          if (out_out0 !== px.b0 || out_out1 !== px.b1 || out_out2 !== px.b2 ||
              out_covered !== px.covered)
            flag_error($sformatf("pixel %0d: expected %h %h %h cov %b, got %h %h %h cov %b",
                                 n_pixels, px.b0, px.b1, px.b2, px.covered,
                                 out_out0, out_out1, out_out2, out_covered));
        end
        n_pixels++;
      end
      // one long hold-off so the input side backs up
      if (!quiet && !long_done && n_pixels >= 40) begin
        stall_left = LONG_STALL;
        long_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycles, pending_px.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int target;
    clear_run();

    //               proj bg        pr c0        c1        c2        weight    in la kn
    add_row(make_row(0, '0,      0, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 0, 0,
                     1, 8'h00, 8'h00, 8'h00, 0));
    add_row(make_row(0, '0,      1, 16'hFF00, 16'hFF00, 16'hFF00, 17'h10000, 1, 1,
                     1, 8'hFF, 8'hFF, 8'hFF, 1));
    add_row(make_row(0, '0,      1, 16'h0000, 16'h0000, 16'h0000, 17'h10000, 0, 1,
                     1, 8'h00, 8'h00, 8'h00, 1));
    // weight above one saturates, channel above 0xff00 still truncates to 255
    add_row(make_row(0, '0,      1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 0, 1,
                     1, 8'hFF, 8'hFF, 8'hFF, 1));
    add_row(make_row(0, BG_TEAL, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 1, 1,
                     1, 8'hC3, 8'h5A, 8'hA5, 0));
    add_row(make_row(0, BG_TEAL, 1, 16'h1234, 16'h5678, 16'h9ABC, 17'h00000, 1, 1,
                     1, 8'hC3, 8'h5A, 8'hA5, 1));
    add_row(make_row(0, BG_TEAL, 1, 16'h4321, 16'h8765, 16'hCBA9, 17'h00000, 0, 1,
                     1, 8'hC3, 8'h5A, 8'hA5, 1));
    // mixed run: only the interior ones count
    add_row(make_row(0, BG_TEAL, 1, 16'h4000, 16'h4000, 16'h4000, 17'h10000, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(0, BG_TEAL, 1, 16'h2000, 16'h3000, 16'h4000, 17'h08000, 1, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(0, BG_TEAL, 1, 16'h8000, 16'h0100, 16'hF000, 17'h04000, 1, 1,
                     0, '0, '0, '0, 0));
    // overlap-only run closed by an absent request
    add_row(make_row(0, BG_TEAL, 1, 16'h1111, 16'h7777, 16'hEEEE, 17'h03000, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(0, BG_TEAL, 1, 16'h9999, 16'h0F0F, 16'h3333, 17'h05000, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(0, BG_TEAL, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 17'h1FFFF, 1, 1,
                     0, '0, '0, '0, 0));
    add_row(make_row(1, BG_WHITE, 0, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 0, 0,
                     1, 8'hFF, 8'hFF, 8'hFF, 0));
    add_row(make_row(1, BG_WHITE, 1, 16'h1234, 16'h5678, 16'h9ABC, 17'h00000, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(1, BG_WHITE, 1, 16'hFFFF, 16'h0000, 16'hFF00, 17'h1FFFF, 1, 1,
                     1, 8'h12, 8'h56, 8'h9A, 1));
    add_row(make_row(1, BG_WHITE, 1, 16'hABCD, 16'h00FF, 16'h8001, 17'h00001, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(1, BG_WHITE, 0, 16'h0000, 16'hFFFF, 16'h0000, 17'h10000, 1, 1,
                     1, 8'hAB, 8'h00, 8'h80, 1));
    // interior seen but its weights sum to zero
    add_row(make_row(0, '0,      1, 16'h8000, 16'h8000, 16'h8000, 17'h10000, 0, 0,
                     0, '0, '0, '0, 0));
    add_row(make_row(0, '0,      1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h00000, 1, 1,
                     1, 8'h00, 8'h00, 8'h00, 1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      // table only switches settings at pixel boundaries
      if (dir_rows[i].proj != cur_proj || dir_rows[i].bg != cur_bg) begin
        settle();
        set_regs(dir_rows[i].proj, dir_rows[i].bg);
      end
      sender_gap();
      push_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].px);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       set_regs(1'b0, BG_WHITE);
        1:       set_regs(1'b1, '0);
        2:       set_regs(1'b0, BG_W'($urandom));
        3:       set_regs(1'b1, BG_W'($urandom));
        default: set_regs(logic'($urandom_range(0, 1)), BG_W'($urandom));
      endcase
      if (p == PHASES - 1) quiet = 1'b1;
      target = dir_rows.size() + (p + 1) * RANDOM_ITEMS / PHASES;
      while (n_items < target) gen_run();
    end

    settle();
    $display("%0d requests in, %0d pixels checked across %0d register settings", n_items,
             n_pixels, n_settings);
    $display("covered empty pixels, projection and blend modes, overlong runs, output stall");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
